FILE: design/deq_pkg.sv
// Shared types, constants and ring helpers for the double-ended queue.
// No dependencies; imported by deq_ram and double_ended_queue_core.
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int DATA_W = 32;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [DATA_W-1:0] ERR_VALUE = '1;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_FRONT      = 3'd4,
        OP_BACK       = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } t_opcode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [DATA_W-1:0]  push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0]  result_value;
        logic                      error;
        logic [CNT_W-1:0]          count;
    } t_out_word;

    // Request from the control logic to the entry memory
    typedef struct packed {
        logic              we;
        logic              re;
        logic [PTR_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } t_ram_req;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        ring_prev = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

endpackage

FILE: design/double_ended_queue_core.sv
// Top level of the double-ended queue: pointers, count, control and result register.
// Depends on deq_pkg and deq_ram.
//
//  channel | direction | valid / ready              | word
//  --------+-----------+----------------------------+-------------
//  in      | to core   | i_in_valid / o_in_ready    | i_in_word
//  out     | from core | o_out_valid / i_out_ready  | o_out_word
//
// Pushes, size, clear and any failing operation put their result out in the cycle after the word is taken.
// A successful pop or peek passes through ST_READ while the registered entry memory read completes.
// A new word is taken while the previous result is being taken in the same cycle.
// Reset clears state, pointers, count and the result valid flag; the result payload and the memory are not cleared.
// A stalled result holds the core; nothing is dropped.
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [PTR_W-1:0]  r_back, n_back;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [PTR_W-1:0]  back_prev;
    logic [PTR_W-1:0]  front_prev;

    deq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == CNT_FULL);
    assign is_empty   = (r_count == '0);
    assign back_prev  = ring_prev(r_back);
    assign front_prev = ring_prev(r_front);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // next state, memory access and result
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_req     = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = '0;
                    n_out.error        = 1'b0;
                    case (i_in_word.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_out.result_value = ERR_VALUE;
                                n_out.error        = 1'b1;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.wdata = i_in_word.push_value;
                                n_count       = r_count + CNT_W'(1);
                                if (i_in_word.opcode == OP_PUSH_FRONT) begin
                                    ram_req.addr = front_prev;
                                    n_front      = front_prev;
                                end else begin
                                    ram_req.addr = r_back;
                                    n_back       = ring_next(r_back);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_FRONT, OP_POP_BACK, OP_BACK: begin
                            if (is_empty) begin
                                n_out.result_value = ERR_VALUE;
                                n_out.error        = 1'b1;
                            end else begin
                                // result comes back from memory next cycle
                                n_out_valid = 1'b0;
                                n_state     = ST_READ;
                                ram_req.re  = 1'b1;
                                if (i_in_word.opcode == OP_POP_FRONT ||
                                    i_in_word.opcode == OP_FRONT) begin
                                    ram_req.addr = r_front;
                                end else begin
                                    ram_req.addr = back_prev;
                                end
                                if (i_in_word.opcode == OP_POP_FRONT) begin
                                    n_front = ring_next(r_front);
                                    n_count = r_count - CNT_W'(1);
                                end else if (i_in_word.opcode == OP_POP_BACK) begin
                                    n_back  = back_prev;
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end
                        OP_SIZE: begin
                            n_out.result_value = {{(DATA_W-CNT_W){1'b0}}, r_count};
                        end
                        OP_CLEAR: begin
                            n_front = '0;
                            n_back  = '0;
                            n_count = '0;
                        end
                        default: begin
                            n_out.error = 1'b0;
                        end
                    endcase
                    n_out.count = n_count;
                end
            end
            ST_READ: begin
                // result slot is always free here
                n_out_valid        = 1'b1;
                n_out.result_value = ram_rdata;
                n_out.error        = 1'b0;
                n_out.count        = r_count;
                n_state            = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // a memory read always completes in the following cycle
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> r_state == ST_IDLE)
        else $error("read state held more than one cycle");

    // the result slot is empty while a read is in flight
    a_slot_free_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |-> !r_out_valid)
        else $error("result slot busy during memory read");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond capacity");

    // empty queue has coinciding pointers
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_front == r_back)
        else $error("pointers differ on empty queue");

    // a full push leaves the count untouched
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_full && (i_in_word.opcode == OP_PUSH_FRONT ||
        i_in_word.opcode == OP_PUSH_BACK) |=> r_count == $past(r_count))
        else $error("push on full queue changed count");

endmodule

FILE: design/deq_ram.sv
// Single-port entry memory of the queue with a registered read.
// Depends on deq_pkg for sizes and the request struct.
module deq_ram
    import deq_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/deq_tb_pkg.sv
// Scoreboard for the double-ended queue testbench: a ring-buffer copy of the queue
// that predicts each result word and checks the core's output against it. Needs deq_pkg.
`timescale 1ns / 100ps

package deq_tb_pkg;

    import deq_pkg::*;

    class deq_result_board;

        // Shadow copy of the queue
        logic [DATA_W-1:0] shadow_mem [DEPTH];
        logic [PTR_W-1:0]  head_ptr;
        logic [PTR_W-1:0]  tail_ptr;
        logic [CNT_W-1:0]  fill;

        t_out_word         expected_words [$];
        int unsigned       mismatches;

        function new();
            head_ptr    = '0;
            tail_ptr    = '0;
            fill        = '0;
            mismatches  = 0;
        endfunction

        function logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
            return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        endfunction

        function logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
            return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Accepted input word: update the shadow queue and queue the expected result
        function void note_word(input t_in_word w);
            t_out_word        r;
            logic [PTR_W-1:0] idx;
            r.result_value = '0;
            r.error        = 1'b0;
            case (w.opcode)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (fill >= CNT_W'(DEPTH)) begin
                        // full: value dropped
                        r.error        = 1'b1;
                        r.result_value = '1;
                    end else if (w.opcode == OP_PUSH_FRONT) begin
                        head_ptr             = wrap_dec(head_ptr);
                        shadow_mem[head_ptr] = w.push_value;
                        fill                 = fill + CNT_W'(1);
                    end else begin
                        shadow_mem[tail_ptr] = w.push_value;
                        tail_ptr             = wrap_inc(tail_ptr);
                        fill                 = fill + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_FRONT: begin
                    if (fill == '0) begin
                        r.error        = 1'b1;
                        r.result_value = '1;
                    end else begin
                        r.result_value = shadow_mem[head_ptr];
                        if (w.opcode == OP_POP_FRONT) begin
                            head_ptr = wrap_inc(head_ptr);
                            fill     = fill - CNT_W'(1);
                        end
                    end
                end
                OP_POP_BACK, OP_BACK: begin
                    if (fill == '0) begin
                        r.error        = 1'b1;
                        r.result_value = '1;
                    end else begin
                        idx            = wrap_dec(tail_ptr);
                        r.result_value = shadow_mem[idx];
                        if (w.opcode == OP_POP_BACK) begin
                            tail_ptr = idx;
                            fill     = fill - CNT_W'(1);
                        end
                    end
                end
                OP_SIZE: begin
                    r.result_value = DATA_W'(fill);
                end
                default: begin
                    head_ptr = '0;
                    tail_ptr = '0;
                    fill     = '0;
                end
            endcase
            r.count = fill;
            expected_words.insert(expected_words.size(), r);
        endfunction

        // Accepted output word: compare against the oldest expectation
        function void check_word(input t_out_word got);
            t_out_word exp_w;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: value %0d error %0d count %0d",
                       got.result_value, got.error, got.count);
                mismatches++;
                return;
            end
            exp_w = expected_words[0];
            expected_words.delete(0);
            if (got.result_value !== exp_w.result_value) begin
                $error("result_value: expected %0d, actual %0d",
                       exp_w.result_value, got.result_value);
                mismatches++;
            end
            if (got.error !== exp_w.error) begin
                $error("error: expected %0d, actual %0d", exp_w.error, got.error);
                mismatches++;
            end
            if (got.count !== exp_w.count) begin
                $error("count: expected %0d, actual %0d", exp_w.count, got.count);
                mismatches++;
            end
        endfunction

    endclass

endpackage

FILE: tb/double_ended_queue_core_tb.sv
// Top of the double-ended queue testbench: clock, reset, word drivers and monitors.
// Needs deq_pkg, deq_tb_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 100ps

module double_ended_queue_core_tb;

    import deq_pkg::*;
    import deq_tb_pkg::*;

    localparam int RANDOM_WORDS = 50;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    deq_result_board board = new();
    int unsigned     words_in = 0;
    bit              long_hold_done = 1'b0;

    double_ended_queue_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word mk_word(input t_opcode op, input logic [DATA_W-1:0] v);
        t_in_word w;
        w.opcode     = op;
        w.push_value = v;
        return w;
    endfunction

    // Random operation; push_pct steers the fill level up or down
    function automatic t_in_word random_word(input int push_pct);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 99);
        if (r == 0)
            return mk_word(OP_CLEAR, $urandom);
        if (r <= push_pct)
            return mk_word(k < 50 ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_value());
        if (k < 30) return mk_word(OP_POP_FRONT, $urandom);
        if (k < 60) return mk_word(OP_POP_BACK, $urandom);
        if (k < 72) return mk_word(OP_FRONT, $urandom);
        if (k < 85) return mk_word(OP_BACK, $urandom);
        return mk_word(OP_SIZE, $urandom);
    endfunction

    // Offer one word, holding valid and payload until the core takes it
    task automatic send_word(input t_in_word w);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Input and output monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            board.note_word(i_in_word);
            words_in++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_word(o_out_word);
    end

    // Receiver: random stalls plus one long hold-off so the core backs up
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && words_in >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                gap = idle_len();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Run limit
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Main sequence
    initial begin
        int push_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty errors, extremes at both ends, drain to empty, clear
        send_word(mk_word(OP_POP_FRONT, $urandom));
        send_word(mk_word(OP_POP_BACK, $urandom));
        send_word(mk_word(OP_FRONT, $urandom));
        send_word(mk_word(OP_BACK, $urandom));
        send_word(mk_word(OP_SIZE, $urandom));
        send_word(mk_word(OP_PUSH_FRONT, 32'h7fff_ffff));
        send_word(mk_word(OP_PUSH_BACK, 32'h8000_0000));
        send_word(mk_word(OP_PUSH_FRONT, 32'hffff_ffff));
        send_word(mk_word(OP_PUSH_BACK, 32'h0000_0000));
        send_word(mk_word(OP_FRONT, $urandom));
        send_word(mk_word(OP_BACK, $urandom));
        send_word(mk_word(OP_SIZE, $urandom));
        send_word(mk_word(OP_POP_FRONT, $urandom));
        send_word(mk_word(OP_POP_BACK, $urandom));
        send_word(mk_word(OP_POP_FRONT, $urandom));
        send_word(mk_word(OP_POP_BACK, $urandom));
        send_word(mk_word(OP_POP_FRONT, $urandom));
        send_word(mk_word(OP_CLEAR, $urandom));
        send_word(mk_word(OP_PUSH_BACK, 32'h5555_5555));
        send_word(mk_word(OP_PUSH_FRONT, 32'haaaa_aaaa));
        send_word(mk_word(OP_CLEAR, $urandom));
        send_word(mk_word(OP_SIZE, $urandom));
        send_word(mk_word(OP_BACK, $urandom));

        // Random mix, fill bias drawn anew every 50 words (so once, as RANDOM_WORDS is 50)
        push_pct = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                push_pct = 25 * $urandom_range(1, 3);
            send_word(random_word(push_pct));
        end

        // Fill to full, push into a full queue, churn near full, then clear
        send_word(mk_word(OP_CLEAR, $urandom));
        for (int n = 0; n < DEPTH + 3; n++)
            send_word(mk_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                              rand_value()));
        send_word(mk_word(OP_SIZE, $urandom));
        send_word(mk_word(OP_FRONT, $urandom));
        send_word(mk_word(OP_BACK, $urandom));
        for (int n = 0; n < 40; n++)
            send_word(random_word(50));
        for (int n = 0; n < 60; n++)
            send_word(random_word(90));
        send_word(mk_word(OP_CLEAR, $urandom));
        send_word(mk_word(OP_SIZE, $urandom));
        i_in_valid <= 1'b0;
        // let the monitor log the last word before looking at the backlog
        @(posedge i_clk);

        // Drain and settle
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
